[hdl/sst_pkg.sv]
// Sorted set table: shared package.
// Sizes, operation and status codes, and the structs passed between core and RAM.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

  // Store size and element width
  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Operation codes; the unused code behaves as a search
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;  // done or found
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;  // duplicate or absent
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;  // insert into full set

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  // Entry store command: write enable, write address and data, read address
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    elem_t            wdata;
    logic [IDX_W-1:0] raddr;
  } ram_cmd_t;

  // Finished result handed to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } result_t;

endpackage

[hdl/sst_req_if.sv]
// Sorted set table: request channel (operation and value).
// Depends on sst_pkg.
`timescale 1ns / 1ps

interface sst_req_if;
  logic                             valid;
  logic                             ready;
  logic [sst_pkg::FUNC_W-1:0]       func;
  logic signed [sst_pkg::VALUE_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

[hdl/sst_rsp_if.sv]
// Sorted set table: response channel (status, entry count, empty flag).
// Depends on sst_pkg.
`timescale 1ns / 1ps

interface sst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sst_pkg::STATUS_W-1:0] status;
  logic [sst_pkg::COUNT_W-1:0]  entry_count;
  logic                         is_empty;

  modport source (output valid, status, entry_count, is_empty, input ready);
  modport sink   (input valid, status, entry_count, is_empty, output ready);
endinterface

[hdl/sorted_set_table_unit.sv]
// Sorted set table: top level with entry store and output register.
// Depends on sst_pkg, sst_req_if, sst_rsp_if, sst_ram and sst_core.
//
// Keeps up to CAPACITY distinct signed values in ascending order. Each request
// beat (insert, remove, search) gives exactly one response beat with a status,
// the entry count after the operation and an empty flag. One request is worked
// at a time: a binary search runs each probe as a RAM read, then a compare,
// for at most log2(CAPACITY)+1 probes, then an insert or remove shifts the
// entries above the hit one per cycle through the single RAM read/write port
// pair. A finished response sits in an output register, so the next request
// can be taken while it waits.
`timescale 1ns / 1ps

module sorted_set_table_unit (
  input  logic     clk,
  input  logic     rst,
  sst_req_if.sink  req,
  sst_rsp_if.source rsp
);

  sst_pkg::ram_cmd_t ram_cmd;
  sst_pkg::elem_t    ram_rdata;
  sst_pkg::result_t  result;
  logic              post;
  logic              post_ok;
  logic              out_valid;

  sst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram_cmd   (ram_cmd),
    .ram_rdata (ram_rdata),
    .post      (post),
    .post_ok   (post_ok),
    .result    (result)
  );

  sst_ram #(
    .WIDTH (sst_pkg::ELEM_WIDTH),
    .DEPTH (sst_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .raddr (ram_cmd.raddr),
    .rdata (ram_rdata)
  );

  // Output register is free when empty or draining this cycle
  assign post_ok   = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post && post_ok) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (post && post_ok) begin
      rsp.status      <= result.status;
      rsp.entry_count <= sst_pkg::COUNT_W'(result.count);
      rsp.is_empty    <= (result.count == '0);
    end
  end

endmodule

[hdl/sst_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sst_core.sv]
// Sorted set table: sequencer. Binary search, then for an insert or remove shifts
// entries through the single RAM port pair one beat per cycle.
// Depends on sst_pkg and sst_req_if.
`timescale 1ns / 1ps

module sst_core (
  input  logic              clk,
  input  logic              rst,
  sst_req_if.sink           req,
  output sst_pkg::ram_cmd_t ram_cmd,
  input  sst_pkg::elem_t    ram_rdata,
  output logic              post,
  input  logic              post_ok,
  output sst_pkg::result_t  result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_DECIDE,
    S_MOVE,
    S_FILL,
    S_POST
  } state_t;

  state_t                       state, state_next;
  logic [sst_pkg::CNT_W-1:0]    count, count_next;
  logic [sst_pkg::FUNC_W-1:0]   func, func_next;
  sst_pkg::elem_t               elem, elem_next;
  logic [sst_pkg::CNT_W-1:0]    lo, lo_next;
  logic [sst_pkg::CNT_W-1:0]    hi, hi_next;
  logic [sst_pkg::CNT_W-1:0]    mid, mid_next;
  logic [sst_pkg::CNT_W-1:0]    pos, pos_next;
  logic                         hit, hit_next;
  logic [sst_pkg::STATUS_W-1:0] status, status_next;
  logic [sst_pkg::IDX_W-1:0]    ptr, ptr_next;
  logic [sst_pkg::IDX_W-1:0]    last, last_next;
  logic [sst_pkg::IDX_W-1:0]    pend_addr, pend_addr_next;
  logic                         pend, pend_next;
  logic                         issuing, issuing_next;
  logic                         dir_up, dir_up_next;
  logic [sst_pkg::CNT_W:0]      mid_sum;
  logic [sst_pkg::CNT_W-1:0]    mid_calc;

  assign req.ready = (state == S_IDLE);
  assign post      = (state == S_POST);
  assign result    = '{status: status, count: count};

  // Probe point of the current search window
  assign mid_sum  = (sst_pkg::CNT_W+1)'(lo) + (sst_pkg::CNT_W+1)'(hi);
  assign mid_calc = mid_sum[sst_pkg::CNT_W:1];

  // Next-state logic
  always_comb begin
    state_next     = state;
    count_next     = count;
    func_next      = func;
    elem_next      = elem;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    pos_next       = pos;
    hit_next       = hit;
    status_next    = status;
    ptr_next       = ptr;
    last_next      = last;
    pend_addr_next = pend_addr;
    pend_next      = pend;
    issuing_next   = issuing;
    dir_up_next    = dir_up;
    ram_cmd        = '{we: 1'b0, waddr: pend_addr, wdata: ram_rdata, raddr: ptr};

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          func_next  = req.func;
          elem_next  = sst_pkg::ELEM_WIDTH'($unsigned(req.value));
          lo_next    = '0;
          hi_next    = count;
          hit_next   = 1'b0;
          state_next = S_SEARCH;
        end
      end

      // Issue a probe read, or finish on an empty window
      S_SEARCH: begin
        if (lo < hi) begin
          ram_cmd.raddr = mid_calc[sst_pkg::IDX_W-1:0];
          mid_next      = mid_calc;
          state_next    = S_CMP;
        end else begin
          pos_next   = lo;
          state_next = S_DECIDE;
        end
      end

      // Shared comparator on the probed entry
      S_CMP: begin
        if (ram_rdata == elem) begin
          hit_next   = 1'b1;
          pos_next   = mid;
          state_next = S_DECIDE;
        end else if ($signed(elem) < $signed(ram_rdata)) begin
          hi_next    = mid;
          state_next = S_SEARCH;
        end else begin
          lo_next    = mid + sst_pkg::CNT_W'(1);
          state_next = S_SEARCH;
        end
      end

      S_DECIDE: begin
        state_next = S_POST;
        case (func)
          sst_pkg::FUNC_INSERT: begin
            if (hit) begin
              status_next = sst_pkg::ST_MISS;
            end else if (count >= sst_pkg::CNT_W'(sst_pkg::CAPACITY)) begin
              status_next = sst_pkg::ST_FULL;
            end else begin
              status_next = sst_pkg::ST_OK;
              count_next  = count + sst_pkg::CNT_W'(1);
              if (pos == count) begin
                // Append at the top, no shift
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = pos[sst_pkg::IDX_W-1:0];
                ram_cmd.wdata = elem;
              end else begin
                ptr_next     = sst_pkg::IDX_W'(count - sst_pkg::CNT_W'(1));
                last_next    = pos[sst_pkg::IDX_W-1:0];
                dir_up_next  = 1'b1;
                issuing_next = 1'b1;
                pend_next    = 1'b0;
                state_next   = S_MOVE;
              end
            end
          end
          sst_pkg::FUNC_REMOVE: begin
            if (!hit) begin
              status_next = sst_pkg::ST_MISS;
            end else begin
              status_next = sst_pkg::ST_OK;
              count_next  = count - sst_pkg::CNT_W'(1);
              if ((pos + sst_pkg::CNT_W'(1)) < count) begin
                ptr_next     = sst_pkg::IDX_W'(pos + sst_pkg::CNT_W'(1));
                last_next    = sst_pkg::IDX_W'(count - sst_pkg::CNT_W'(1));
                dir_up_next  = 1'b0;
                issuing_next = 1'b1;
                pend_next    = 1'b0;
                state_next   = S_MOVE;
              end
            end
          end
          default: begin
            status_next = hit ? sst_pkg::ST_OK : sst_pkg::ST_MISS;
          end
        endcase
      end

      // Streamed shift: read one entry, write the previous one a place over
      S_MOVE: begin
        ram_cmd.we = pend;
        if (issuing) begin
          pend_next      = 1'b1;
          pend_addr_next = dir_up ? ptr + sst_pkg::IDX_W'(1) : ptr - sst_pkg::IDX_W'(1);
          if (ptr == last) begin
            issuing_next = 1'b0;
          end else begin
            ptr_next = dir_up ? ptr - sst_pkg::IDX_W'(1) : ptr + sst_pkg::IDX_W'(1);
          end
        end else begin
          pend_next  = 1'b0;
          state_next = dir_up ? S_FILL : S_POST;
        end
      end

      // Place the inserted value into the opened gap
      S_FILL: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = pos[sst_pkg::IDX_W-1:0];
        ram_cmd.wdata = elem;
        state_next    = S_POST;
      end

      S_POST: begin
        if (post_ok) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      issuing <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pend    <= pend_next;
      issuing <= issuing_next;
    end
    func      <= func_next;
    elem      <= elem_next;
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    pos       <= pos_next;
    hit       <= hit_next;
    status    <= status_next;
    ptr       <= ptr_next;
    last      <= last_next;
    pend_addr <= pend_addr_next;
    dir_up    <= dir_up_next;
  end

  // Count never exceeds the store size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // The store is never written while a search is under way
  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_CMP) |-> !ram_cmd.we)
    else $error("store written during search");

  // Count changes only when an operation is resolved
  a_count_only_decide: assert property (@(posedge clk) disable iff (rst)
    (state != S_DECIDE) |=> $stable(count))
    else $error("entry count changed outside resolve");

  // A posted result holds until the output stage takes it
  a_post_holds: assert property (@(posedge clk) disable iff (rst)
    (post && !post_ok) |=> (post && $stable(result)))
    else $error("posted result dropped or changed");

  // An accepted beat starts a search
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_SEARCH))
    else $error("accepted beat did not start a search");

endmodule

[bench/tb_top.sv]
// Testbench for sorted_set_table_unit: random and directed insert/remove/search requests
// checked beat by beat against a sorted-queue predictor of the set.
// Depends on sst_pkg, sst_req_if, sst_rsp_if and the sorted_set_table_unit RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int POOL_SIZE   = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef logic signed [sst_pkg::ELEM_WIDTH-1:0] member_t;

  typedef struct {
    logic [sst_pkg::FUNC_W-1:0]         func;
    logic signed [sst_pkg::VALUE_W-1:0] value;
  } op_beat_t;

  typedef struct packed {
    logic [sst_pkg::STATUS_W-1:0] status;
    logic [sst_pkg::COUNT_W-1:0]  entry_count;
    logic                         is_empty;
  } set_reply_t;

  logic clk = 1'b0;
  logic rst;

  sst_req_if req_bus ();
  sst_rsp_if rsp_bus ();

  sorted_set_table_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #2 clk = ~clk;

  // Predicted set contents (ascending) and outstanding reply predictions
  member_t    held_q[$];
  set_reply_t reply_expect_q[$];
  op_beat_t   op_pending_q[$];
  member_t    value_pool[POOL_SIZE];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles;

  // Apply one operation to the predicted set and return the reply it gives
  function automatic set_reply_t set_apply(op_beat_t op);
    int      pos;
    bit      hit;
    member_t v;
    set_reply_t r;
    v   = op.value[sst_pkg::ELEM_WIDTH-1:0];
    pos = 0;
    while (pos < held_q.size() && held_q[pos] < v) pos++;
    hit = (pos < held_q.size()) && (held_q[pos] == v);
    case (op.func)
      sst_pkg::FUNC_INSERT: begin
        if (hit) begin
          r.status = sst_pkg::ST_MISS;
        end else if (held_q.size() >= sst_pkg::CAPACITY) begin
          r.status = sst_pkg::ST_FULL;
        end else begin
          held_q.insert(pos, v);
          r.status = sst_pkg::ST_OK;
        end
      end
      sst_pkg::FUNC_REMOVE: begin
        if (hit) begin
          held_q.delete(pos);
          r.status = sst_pkg::ST_OK;
        end else begin
          r.status = sst_pkg::ST_MISS;
        end
      end
      // search, and the unused code which acts as one
      default: r.status = hit ? sst_pkg::ST_OK : sst_pkg::ST_MISS;
    endcase
    r.entry_count = sst_pkg::COUNT_W'(held_q.size());
    r.is_empty    = (held_q.size() == 0);
    return r;
  endfunction

  // Request driver: offers the oldest pending op, predicts on acceptance
  always @(posedge clk) begin : req_drive
    bit offer;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready)
        reply_expect_q.push_back(set_apply(op_pending_q.pop_front()));
      if (!req_bus.valid || req_bus.ready) begin
        offer = (op_pending_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        req_bus.valid <= offer;
        if (offer) begin
          req_bus.func  <= op_pending_q[0].func;
          req_bus.value <= op_pending_q[0].value;
        end
      end
    end
  end

  // Reply monitor: checks each beat, drives ready with random and long stalls
  always @(posedge clk) begin : rsp_check
    set_reply_t got;
    set_reply_t want;
    bit stall;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{rsp_bus.status, rsp_bus.entry_count, rsp_bus.is_empty};
        if (reply_expect_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected reply, expected none, got status %0d count %0d empty %0d",
                   $time, got.status, got.entry_count, got.is_empty);
        end else begin
          want = reply_expect_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            $display({"%0t: expected status %0d count %0d empty %0d, ",
                      "got status %0d count %0d empty %0d"},
                     $time, want.status, want.entry_count, want.is_empty,
                     got.status, got.entry_count, got.is_empty);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (hold_request != 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        stall        = 1'b1;
      end else begin
        stall = $urandom_range(99) < recv_idle_pct;
      end
      rsp_bus.ready <= !stall;
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(logic [sst_pkg::FUNC_W-1:0] func,
                          logic signed [sst_pkg::VALUE_W-1:0] value);
    op_beat_t op;
    op.func  = func;
    op.value = value;
    op_pending_q.push_back(op);
  endtask

  task automatic wait_drained();
    while (op_pending_q.size() != 0 || reply_expect_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [sst_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(9) == 0) return $urandom();
    return value_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // Random ops in runs biased toward growing, shrinking or churning the set
  task automatic queue_random(int n);
    int unsigned mode;
    int unsigned r;
    logic [sst_pkg::FUNC_W-1:0] f;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0: begin
          f = (r < 70) ? sst_pkg::FUNC_INSERT : (r < 85) ? sst_pkg::FUNC_REMOVE :
              (r < 96) ? sst_pkg::FUNC_SEARCH : sst_pkg::FUNC_UNUSED;
        end
        1: begin
          f = (r < 15) ? sst_pkg::FUNC_INSERT : (r < 75) ? sst_pkg::FUNC_REMOVE :
              (r < 96) ? sst_pkg::FUNC_SEARCH : sst_pkg::FUNC_UNUSED;
        end
        default: begin
          f = (r < 35) ? sst_pkg::FUNC_INSERT : (r < 70) ? sst_pkg::FUNC_REMOVE :
              (r < 95) ? sst_pkg::FUNC_SEARCH : sst_pkg::FUNC_UNUSED;
        end
      endcase
      queue_op(f, pick_value());
    end
  endtask

  // Insert the whole pool, driving the set to full; later inserts hit full or duplicate
  task automatic queue_fill();
    for (int i = 0; i < POOL_SIZE; i++) queue_op(sst_pkg::FUNC_INSERT, value_pool[i]);
    queue_op(sst_pkg::FUNC_INSERT, $urandom());
    queue_op(sst_pkg::FUNC_SEARCH, value_pool[POOL_SIZE - 1]);
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.func  = sst_pkg::FUNC_INSERT;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 0;

    // Pool: extremes, a tight cluster around zero, then spread values
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < 25; i++) value_pool[i] = $signed($urandom_range(40)) - 20;
    for (int i = 25; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set, extremes, duplicate, hits and misses, unused code, drain to empty
    queue_op(sst_pkg::FUNC_SEARCH, 0);
    queue_op(sst_pkg::FUNC_REMOVE, 5);
    queue_op(sst_pkg::FUNC_INSERT, 0);
    queue_op(sst_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
    queue_op(sst_pkg::FUNC_INSERT, 32'sh8000_0000);
    queue_op(sst_pkg::FUNC_INSERT, -1);
    queue_op(sst_pkg::FUNC_INSERT, 1);
    queue_op(sst_pkg::FUNC_INSERT, 0);
    queue_op(sst_pkg::FUNC_SEARCH, 32'sh8000_0000);
    queue_op(sst_pkg::FUNC_SEARCH, 32'sh7FFF_FFFF);
    queue_op(sst_pkg::FUNC_SEARCH, 2);
    queue_op(sst_pkg::FUNC_UNUSED, -1);
    queue_op(sst_pkg::FUNC_UNUSED, 12345);
    queue_op(sst_pkg::FUNC_REMOVE, 0);
    queue_op(sst_pkg::FUNC_REMOVE, 32'sh8000_0000);
    queue_op(sst_pkg::FUNC_REMOVE, 32'sh7FFF_FFFF);
    queue_op(sst_pkg::FUNC_REMOVE, 0);
    queue_op(sst_pkg::FUNC_INSERT, 32'sh5555_5555);
    queue_op(sst_pkg::FUNC_INSERT, 32'shAAAA_AAAA);
    queue_op(sst_pkg::FUNC_REMOVE, -1);
    queue_op(sst_pkg::FUNC_REMOVE, 1);
    queue_op(sst_pkg::FUNC_REMOVE, 32'sh5555_5555);
    queue_op(sst_pkg::FUNC_REMOVE, 32'shAAAA_AAAA);
    wait_drained();

    // Three idle profiles; each phase pauses mid-way until all replies are back
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_request  = LONG_HOLD;
        end
      endcase
      if (phase != 1) queue_fill();
      queue_random(100);
      wait_drained();
      queue_random(90);
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
